/* hdl/dvu_pkg.sv */
// Package for the distance-vector update block: widths, node count, cost
// constants, item type and the mode codes. No dependencies.
`timescale 1ns / 1ps

package dvu_pkg;

  localparam int NODE_COUNT = 4;
  localparam int NODE_W     = 2;
  localparam int COST_W     = 10;

  localparam logic [COST_W-1:0] UNREACHABLE_COST = COST_W'(999);

  typedef logic [COST_W-1:0] cost_t;
  typedef cost_t [NODE_COUNT-1:0] cost_vec_t;

  // Direct link costs after reset: node 1 is this node.
  localparam cost_vec_t LINK_RESET = '{UNREACHABLE_COST, COST_W'(1), COST_W'(0), COST_W'(1)};

  typedef enum logic {
    MODE_INIT   = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [NODE_W-1:0] source_node;
    cost_t             adv_cost_dest0;
    cost_t             adv_cost_dest1;
    cost_t             adv_cost_dest2;
    cost_t             adv_cost_dest3;
  } item_t;

endpackage

/* hdl/dvu_channels.sv */
// Valid/ready channel interfaces for update items and cost vectors.
// Depends on dvu_pkg.
`timescale 1ns / 1ps

interface dvu_update_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [dvu_pkg::NODE_W-1:0] source_node;
  dvu_pkg::cost_t            adv_cost_dest0;
  dvu_pkg::cost_t            adv_cost_dest1;
  dvu_pkg::cost_t            adv_cost_dest2;
  dvu_pkg::cost_t            adv_cost_dest3;

  modport source (output valid, mode, source_node, adv_cost_dest0, adv_cost_dest1,
                  adv_cost_dest2, adv_cost_dest3, input ready);
  modport sink   (input valid, mode, source_node, adv_cost_dest0, adv_cost_dest1,
                  adv_cost_dest2, adv_cost_dest3, output ready);
endinterface

interface dvu_vector_if;
  logic           valid;
  logic           ready;
  dvu_pkg::cost_t best_cost_dest0;
  dvu_pkg::cost_t best_cost_dest1;
  dvu_pkg::cost_t best_cost_dest2;
  dvu_pkg::cost_t best_cost_dest3;

  modport source (output valid, best_cost_dest0, best_cost_dest1, best_cost_dest2,
                  best_cost_dest3, input ready);
  modport sink   (input valid, best_cost_dest0, best_cost_dest1, best_cost_dest2,
                  best_cost_dest3, output ready);
endinterface

/* hdl/dvu_table.sv */
// Cost table and least-cost vector with the combinational update logic.
// Depends on dvu_pkg.
`timescale 1ns / 1ps

module dvu_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  dvu_pkg::item_t     item,
  input  dvu_pkg::cost_vec_t link_cost,
  output dvu_pkg::cost_vec_t best_next,
  output logic               emit
);

  dvu_pkg::cost_t best_costs [dvu_pkg::NODE_COUNT];
  dvu_pkg::cost_t cost_table [dvu_pkg::NODE_COUNT][dvu_pkg::NODE_COUNT];
  dvu_pkg::cost_t table_next [dvu_pkg::NODE_COUNT][dvu_pkg::NODE_COUNT];

  dvu_pkg::cost_t           via;
  dvu_pkg::cost_vec_t       adv;
  dvu_pkg::cost_vec_t       cand;
  logic [dvu_pkg::COST_W:0] sum [dvu_pkg::NODE_COUNT];
  logic                     fell;

  assign via = best_costs[item.source_node];
  assign adv = {item.adv_cost_dest3, item.adv_cost_dest2,
                item.adv_cost_dest1, item.adv_cost_dest0};

  always_comb begin
    for (int d = 0; d < dvu_pkg::NODE_COUNT; d++) begin
      sum[d]  = {1'b0, via} + {1'b0, adv[d]};
      cand[d] = (sum[d] > {1'b0, dvu_pkg::UNREACHABLE_COST}) ?
                dvu_pkg::UNREACHABLE_COST : sum[d][dvu_pkg::COST_W-1:0];
    end
  end

  always_comb begin
    for (int d = 0; d < dvu_pkg::NODE_COUNT; d++) begin
      for (int h = 0; h < dvu_pkg::NODE_COUNT; h++) begin
        if (item.mode == dvu_pkg::MODE_INIT) begin
          if (d == h) begin
            table_next[d][h] = (link_cost[d] > dvu_pkg::UNREACHABLE_COST) ?
                               dvu_pkg::UNREACHABLE_COST : link_cost[d];
          end else begin
            table_next[d][h] = dvu_pkg::UNREACHABLE_COST;
          end
        end else if (dvu_pkg::NODE_W'(h) == item.source_node &&
                     cand[d] < cost_table[d][h]) begin
          table_next[d][h] = cand[d];
        end else begin
          table_next[d][h] = cost_table[d][h];
        end
      end
    end
  end

  // Row minima of the updated table; a result goes out on init or when one fell.
  always_comb begin
    fell = 1'b0;
    for (int d = 0; d < dvu_pkg::NODE_COUNT; d++) begin
      best_next[d] = table_next[d][0];
      for (int h = 1; h < dvu_pkg::NODE_COUNT; h++) begin
        if (table_next[d][h] < best_next[d]) begin
          best_next[d] = table_next[d][h];
        end
      end
      if (best_next[d] < best_costs[d]) begin
        fell = 1'b1;
      end
    end
    emit = (item.mode == dvu_pkg::MODE_INIT) || fell;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < dvu_pkg::NODE_COUNT; d++) begin
        best_costs[d] <= dvu_pkg::UNREACHABLE_COST;
        for (int h = 0; h < dvu_pkg::NODE_COUNT; h++) begin
          cost_table[d][h] <= dvu_pkg::UNREACHABLE_COST;
        end
      end
    end else if (step) begin
      for (int d = 0; d < dvu_pkg::NODE_COUNT; d++) begin
        best_costs[d] <= best_next[d];
        for (int h = 0; h < dvu_pkg::NODE_COUNT; h++) begin
          cost_table[d][h] <= table_next[d][h];
        end
      end
    end
  end

endmodule

/* hdl/distance_vector_update_top.sv */
// Top level of the distance-vector routing node: input register, link cost
// registers, result register. Depends on dvu_pkg, dvu_channels, dvu_table.
//
//   channel  dir  handshake     contents
//   upd      in   valid/ready   mode, source_node, adv_cost_dest0..3
//   res      out  valid/ready   best_cost_dest0..3
//   cfg      in   cfg_we        cfg_index, cfg_data (link costs 0..3)
//
// One item per cycle sustained while the result is not stalled; an accepted item
// is held in the input register, and the table update and row minima go from
// it into the result register. Reset clears the table and the vector to
// unreachable and the link costs to their defaults. A stalled result holds the
// pipeline; upd.ready stays high while the input register is empty or moving on.
`timescale 1ns / 1ps

module distance_vector_update_top (
  input  logic                        clk,
  input  logic                        rst,
  dvu_update_if.sink                  upd,
  dvu_vector_if.source                res,
  input  logic                        cfg_we,
  input  logic [dvu_pkg::NODE_W-1:0]  cfg_index,
  input  dvu_pkg::cost_t              cfg_data
);

  dvu_pkg::cost_vec_t link_cost;
  dvu_pkg::item_t     in_item;
  logic               in_valid;
  dvu_pkg::cost_vec_t res_vec;
  logic               res_valid;
  dvu_pkg::cost_vec_t best_next;
  logic               emit;
  logic               advance;

  assign advance   = in_valid && (!res_valid || res.ready);
  assign upd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_cost <= dvu_pkg::LINK_RESET;
    end else if (cfg_we) begin
      link_cost[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (upd.valid && upd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.valid && upd.ready) begin
      in_item.mode           <= dvu_pkg::mode_t'(upd.mode);
      in_item.source_node    <= upd.source_node;
      in_item.adv_cost_dest0 <= upd.adv_cost_dest0;
      in_item.adv_cost_dest1 <= upd.adv_cost_dest1;
      in_item.adv_cost_dest2 <= upd.adv_cost_dest2;
      in_item.adv_cost_dest3 <= upd.adv_cost_dest3;
    end
  end

  dvu_table u_table (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .link_cost (link_cost),
    .best_next (best_next),
    .emit      (emit)
  );

  // An update that lowers no minimum retires without a result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_vec <= best_next;
    end
  end

  assign res.valid           = res_valid;
  assign res.best_cost_dest0 = res_vec[0];
  assign res.best_cost_dest1 = res_vec[1];
  assign res.best_cost_dest2 = res_vec[2];
  assign res.best_cost_dest3 = res_vec[3];

endmodule
